### sv/sxtok_pkg.sv
// ----------------------------------------------------------------------------
// S-expression tokenizer package
// Shared widths, character codes, token kinds and result types.
// ----------------------------------------------------------------------------
package sxtok_pkg;

	// Width of the integer accumulator; values wrap at this width.
	localparam int VALUE_WIDTH = 64;
	localparam int OUT_VALUE_W = 64;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int RADIX = 10;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8 + OUT_VALUE_W;
	localparam int M_TUSER_W = 6;

	localparam logic [2:0] KIND_SYMBOL  = 3'd0;
	localparam logic [2:0] KIND_INTEGER = 3'd1;
	localparam logic [2:0] KIND_TEXT    = 3'd2;
	localparam logic [2:0] KIND_OPEN    = 3'd3;
	localparam logic [2:0] KIND_CLOSE   = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic                   lex_error;
		logic [OUT_VALUE_W-1:0] integer_value;
		logic                   token_last;
		logic                   token_first;
		logic                   byte_present;
		logic [7:0]             byte_value;
		logic [2:0]             token_kind;
	} result_t;

	// Up to two results per accepted byte go from the lexer to the queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t mk_result(input logic [2:0] kind, input logic [7:0] b,
			input logic present, input logic first, input logic last,
			input logic [OUT_VALUE_W-1:0] value, input logic err);
		result_t r;
		r.token_kind    = kind;
		r.byte_value    = b;
		r.byte_present  = present;
		r.token_first   = first;
		r.token_last    = last;
		r.integer_value = value;
		r.lex_error     = err;
		return r;
	endfunction

	function automatic result_t mk_error();
		return mk_result(KIND_SYMBOL, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b1);
	endfunction

	function automatic logic [OUT_VALUE_W-1:0] sext_value(input logic [VALUE_WIDTH-1:0] v);
		return OUT_VALUE_W'(signed'(v));
	endfunction

endpackage

### sv/s_expression_tokenizer_core.sv
// A token byte enters the result queue when the byte that ends or follows it is accepted.
// Throughput: one source byte per cycle with s_tready high; one result per cycle with m_tready high.
// A byte that closes a token with ')' yields two results; the four-entry result queue absorbs them.
// Reset: arst_n clears the lexer mode, the held byte, the accumulators and the queue at once.
// ----------------------------------------------------------------------------
// S-expression tokenizer core
// Streams source bytes in and token bytes out, with a lexer front and a
// result queue between the two stream sides.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sxtok_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] data_byte
	input  logic                               s_tlast,  // end_of_input
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sxtok_pkg::M_TDATA_W-1:0]    m_tdata,  // [7:0] byte_value, [71:8] integer_value
	output logic [sxtok_pkg::M_TUSER_W-1:0]    m_tuser,  // [2:0] token_kind, [3] byte_present,
	                                                     // [4] token_first, [5] lex_error
	output logic                               m_tlast   // token_last
);
	import sxtok_pkg::*;

	push_t   push;
	result_t res;
	logic    space;

	assign s_tready = space;

	sxtok_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s_tvalid && space),
		.data_byte    (s_tdata[7:0]),
		.end_of_input (s_tlast),
		.push         (push)
	);

	sxtok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.integer_value, res.byte_value};
	assign m_tuser = {res.lex_error, res.token_first, res.byte_present, res.token_kind};
	assign m_tlast = res.token_last;

endmodule

### sv/sxtok_front.sv
// ----------------------------------------------------------------------------
// S-expression tokenizer lexer front
// Classifies each accepted byte, keeps the held-back token byte and the
// integer accumulators, and hands up to two results per byte to the queue.
// ----------------------------------------------------------------------------
module sxtok_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	input  logic            end_of_input,
	output sxtok_pkg::push_t push
);
	import sxtok_pkg::*;

	localparam logic [2:0] M_IDLE        = 3'd0;
	localparam logic [2:0] M_SIGN        = 3'd1;
	localparam logic [2:0] M_NUMBER      = 3'd2;
	localparam logic [2:0] M_SYMBOL      = 3'd3;
	localparam logic [2:0] M_TEXT        = 3'd4;
	localparam logic [2:0] M_TEXT_CLOSED = 3'd5;
	localparam logic [2:0] M_DRAIN       = 3'd6;

	logic [2:0]             mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic                   held_valid_q, held_valid_d;
	logic                   held_first_q, held_first_d;
	logic                   negative_q, negative_d;
	// The negated value is tracked beside the value so the result needs no extra adder.
	logic [VALUE_WIDTH-1:0] acc_q, acc_d, neg_q, neg_d;

	logic [VALUE_WIDTH-1:0] digit, acc_dig, neg_dig;
	logic [OUT_VALUE_W-1:0] value_old, value_new_pos, value_new_keep;
	logic                   is_ws, is_cp, is_dig;
	result_t                old_r, r0, r1;
	logic [1:0]             cnt;

	assign is_ws  = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_NL);
	assign is_cp  = (data_byte == CH_CLOSE);
	assign is_dig = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

	assign digit   = VALUE_WIDTH'(data_byte[3:0]);
	assign acc_dig = (mode_q == M_NUMBER) ? acc_q * VALUE_WIDTH'(RADIX) + digit : digit;
	assign neg_dig = (mode_q == M_NUMBER) ? neg_q * VALUE_WIDTH'(RADIX) - digit
		: '0 - digit;

	assign value_old      = sext_value(negative_q ? neg_q : acc_q);
	assign value_new_pos  = sext_value(acc_dig);
	assign value_new_keep = sext_value(negative_q ? neg_dig : acc_dig);

	always_comb begin
		mode_d       = mode_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		held_first_d = held_first_q;
		negative_d   = negative_q;
		acc_d        = acc_q;
		neg_d        = neg_q;
		cnt          = 2'd0;
		r0           = '0;
		r1           = '0;
		old_r        = mk_result(KIND_SYMBOL, held_q, 1'b1, held_first_q, 1'b0, '0, 1'b0);

		unique case (mode_q)
			M_IDLE: begin
				if (!is_ws) begin
					if (data_byte == CH_OPEN || is_cp) begin
						r0 = mk_result(is_cp ? KIND_CLOSE : KIND_OPEN, data_byte, 1'b1, 1'b1,
							1'b1, '0, 1'b0);
						cnt = 2'd1;
					end else if (is_dig) begin
						mode_d = M_NUMBER;
						acc_d = acc_dig;
						neg_d = neg_dig;
						negative_d = 1'b0;
						held_d = data_byte; held_valid_d = 1'b1; held_first_d = 1'b1;
						r0 = mk_result(KIND_INTEGER, data_byte, 1'b1, 1'b1, 1'b1,
							value_new_pos, 1'b0);
						cnt = end_of_input ? 2'd1 : 2'd0;
					end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
						mode_d = M_SIGN;
						acc_d = '0;
						neg_d = '0;
						negative_d = (data_byte == CH_MINUS);
						held_d = data_byte; held_valid_d = 1'b1; held_first_d = 1'b1;
						r0 = mk_result(KIND_SYMBOL, data_byte, 1'b1, 1'b1, 1'b1, '0, 1'b0);
						cnt = end_of_input ? 2'd1 : 2'd0;
					end else if (data_byte == CH_QUOTE) begin
						mode_d = M_TEXT;
						held_valid_d = 1'b0;
						r0 = mk_error();
						cnt = end_of_input ? 2'd1 : 2'd0;
					end else begin
						mode_d = M_SYMBOL;
						held_d = data_byte; held_valid_d = 1'b1; held_first_d = 1'b1;
						r0 = mk_result(KIND_SYMBOL, data_byte, 1'b1, 1'b1, 1'b1, '0, 1'b0);
						cnt = end_of_input ? 2'd1 : 2'd0;
					end
				end
			end
			M_SIGN, M_NUMBER, M_SYMBOL: begin
				if (is_dig && mode_q != M_SYMBOL) begin
					// The held sign or digit is part of an integer.
					r0 = old_r;
					r0.token_kind = KIND_INTEGER;
					mode_d = M_NUMBER;
					acc_d = acc_dig;
					neg_d = neg_dig;
					held_d = data_byte; held_valid_d = 1'b1; held_first_d = 1'b0;
					r1 = mk_result(KIND_INTEGER, data_byte, 1'b1, 1'b0, 1'b1,
						value_new_keep, 1'b0);
					cnt = end_of_input ? 2'd2 : 2'd1;
				end else if (is_ws || is_cp) begin
					r0 = old_r;
					r0.token_last = 1'b1;
					if (mode_q == M_NUMBER) begin
						r0.token_kind = KIND_INTEGER;
						r0.integer_value = value_old;
					end
					r1 = mk_result(KIND_CLOSE, CH_CLOSE, 1'b1, 1'b1, 1'b1, '0, 1'b0);
					cnt = is_cp ? 2'd2 : 2'd1;
					mode_d = M_IDLE;
				end else if (mode_q == M_NUMBER) begin
					r0 = mk_error();
					cnt = 2'd1;
					mode_d = M_DRAIN;
				end else begin
					r0 = old_r;
					mode_d = M_SYMBOL;
					held_d = data_byte; held_valid_d = 1'b1; held_first_d = 1'b0;
					r1 = mk_result(KIND_SYMBOL, data_byte, 1'b1, 1'b0, 1'b1, '0, 1'b0);
					cnt = end_of_input ? 2'd2 : 2'd1;
				end
			end
			M_TEXT: begin
				if (data_byte == CH_QUOTE) begin
					mode_d = M_TEXT_CLOSED;
					r0 = held_valid_q
						? mk_result(KIND_TEXT, held_q, 1'b1, held_first_q, 1'b1, '0, 1'b0)
						: mk_result(KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b1, '0, 1'b0);
					cnt = end_of_input ? 2'd1 : 2'd0;
				end else if (end_of_input) begin
					r0 = mk_error();
					cnt = 2'd1;
				end else begin
					r0 = old_r;
					r0.token_kind = KIND_TEXT;
					cnt = held_valid_q ? 2'd1 : 2'd0;
					held_d = data_byte; held_valid_d = 1'b1; held_first_d = !held_valid_q;
				end
			end
			M_TEXT_CLOSED: begin
				if (is_ws || is_cp) begin
					r0 = held_valid_q
						? mk_result(KIND_TEXT, held_q, 1'b1, held_first_q, 1'b1, '0, 1'b0)
						: mk_result(KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b1, '0, 1'b0);
					r1 = mk_result(KIND_CLOSE, CH_CLOSE, 1'b1, 1'b1, 1'b1, '0, 1'b0);
					cnt = is_cp ? 2'd2 : 2'd1;
					mode_d = M_IDLE;
				end else begin
					r0 = mk_error();
					cnt = 2'd1;
					mode_d = M_DRAIN;
				end
			end
			M_DRAIN: begin
			end
			default: begin
				mode_d = M_IDLE;
			end
		endcase

		// The last byte of a source returns everything to the reset state.
		if (end_of_input) begin
			mode_d       = M_IDLE;
			held_d       = 8'h00;
			held_valid_d = 1'b0;
			held_first_d = 1'b0;
			negative_d   = 1'b0;
			acc_d        = '0;
			neg_d        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b0;
			negative_q   <= 1'b0;
			acc_q        <= '0;
			neg_q        <= '0;
		end else if (fire) begin
			mode_q       <= mode_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			held_first_q <= held_first_d;
			negative_q   <= negative_d;
			acc_q        <= acc_d;
			neg_q        <= neg_d;
		end
	end

	assign push.count = fire ? cnt : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

endmodule

### sv/sxtok_queue.sv
// ----------------------------------------------------------------------------
// S-expression tokenizer result queue
// Takes up to two results per cycle from the lexer and presents one result
// per cycle to the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module sxtok_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  sxtok_pkg::push_t   push,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output sxtok_pkg::result_t out_res
);
	import sxtok_pkg::*;

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = entry_q[rd_ptr_q];
	// Room for the worst case of two results from the next byte.
	assign space     = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + QPTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

### sv/sxtok_checker.sv
// ----------------------------------------------------------------------------
// S-expression tokenizer port checker
// Watches the output stream of the core for malformed result items.
// ----------------------------------------------------------------------------
module sxtok_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sxtok_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [sxtok_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                            m_tlast
);
	import sxtok_pkg::*;

	// A stalled transfer keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	// An error result carries no other content.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[5] |-> m_tdata == '0 && m_tuser[4:0] == '0 && !m_tlast)
		else $error("error result with content");

	// Parentheses are single-byte tokens.
	a_paren: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[5] && (m_tuser[2:0] == KIND_OPEN || m_tuser[2:0] == KIND_CLOSE)
			|-> m_tuser[4] && m_tlast && m_tuser[3])
		else $error("parenthesis token not single byte");

	// The value field is only used on the last byte of an integer.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser[2:0] == KIND_INTEGER && m_tlast) |-> m_tdata[M_TDATA_W-1:8] == '0)
		else $error("value outside the last integer byte");

	// A missing byte only happens for an empty text.
	a_empty_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] && !m_tuser[5]
			|-> m_tuser[2:0] == KIND_TEXT && m_tuser[4] && m_tlast)
		else $error("absent byte outside an empty text");

endmodule

bind s_expression_tokenizer_core sxtok_checker u_sxtok_checker (.*);
